>>> rtl/jts_pkg.sv
`timescale 1ns / 1ps
// shared types, register codes and constants for the jacobi solver
package jts_pkg;

  localparam int MAX_SIZE_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int CFG_WIDTH       = 13;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [1:0] REG_PROBLEM_SIZE = 2'd0;
  localparam logic [1:0] REG_ITER_LIMIT   = 2'd1;
  localparam logic [1:0] REG_TOL_SHIFT    = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  localparam logic [6:0]  PROBLEM_SIZE_RST = 7'd64;
  localparam logic [12:0] ITER_LIMIT_RST   = 13'd5000;
  localparam logic [5:0]  TOL_SHIFT_RST    = 6'd40;

  localparam logic [63:0] ABS_SQ_MAX = 64'd3037000499;
  localparam logic [62:0] RES_MAX    = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [6:0]  problem_size;
    logic [12:0] iteration_limit;
    logic [5:0]  tolerance_shift;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [5:0]  index;
    logic [31:0] rhs_value;
  } item_t;

endpackage

>>> rtl/jacobi_tridiagonal_solver_unit.sv
`timescale 1ns / 1ps
// top level: jacobi solver for the 1-d poisson system, queue-style ports
// load transaction: written to the rhs store as it leaves the 4-entry input queue
// solve transaction: repeated sweeps over the n unknowns, then the solution elements leave one
//   at a time through the output register; each sweep does one read and one write a cycle
// throughput: one transaction at a time in the engine, loads sustain one per cycle
// reset (synchronous, rst_n low): queues empty, registers to 64 / 5000 / 40, no clearing pass
module jacobi_tridiagonal_solver_unit import jts_pkg::*; #(
  parameter int MAX_SIZE    = MAX_SIZE_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 push,
  output logic                 full,
  input  logic                 in_op,
  input  logic [5:0]           in_index,
  input  logic signed [31:0]   in_rhs_value,
  // result channel
  output logic                 empty,
  input  logic                 pop,
  output logic [5:0]           out_position,
  output logic signed [31:0]   out_solution_value,
  output logic [13:0]          out_sweep_count,
  output logic [62:0]          out_residual_squared,
  output logic                 out_limit_hit,
  output logic                 out_last,
  // configuration
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data
);

  cfg_t  cfg_r;
  item_t in_item;
  item_t head_item;
  logic  head_vld;
  logic  head_is_solve;
  logic  take;
  logic  out_valid;
  logic [31:0] sol_value;

  // configuration registers; the user must write them only while the block is idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.problem_size    <= PROBLEM_SIZE_RST;
      cfg_r.iteration_limit <= ITER_LIMIT_RST;
      cfg_r.tolerance_shift <= TOL_SHIFT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROBLEM_SIZE: cfg_r.problem_size    <= cfg_data[6:0];
        REG_ITER_LIMIT:   cfg_r.iteration_limit <= cfg_data[12:0];
        REG_TOL_SHIFT:    cfg_r.tolerance_shift <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign in_item.op        = in_op;
  assign in_item.index     = in_index;
  assign in_item.rhs_value = in_rhs_value;

  // front: accepts and classifies transactions
  jts_item_queue u_queue (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .in_item       (in_item),
    .full          (full),
    .head_vld      (head_vld),
    .head_item     (head_item),
    .head_is_solve (head_is_solve),
    .take          (take)
  );

  // back: loads, sweeps and emission through the output register
  jts_engine #(
    .MAX_SIZE    (MAX_SIZE),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_engine (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .q_vld                (head_vld),
    .q_item               (head_item),
    .q_is_solve           (head_is_solve),
    .q_take               (take),
    .out_valid            (out_valid),
    .out_take             (pop),
    .out_position         (out_position),
    .out_solution_value   (sol_value),
    .out_sweep_count      (out_sweep_count),
    .out_residual_squared (out_residual_squared),
    .out_limit_hit        (out_limit_hit),
    .out_last             (out_last)
  );

  assign out_solution_value = $signed(sol_value);
  assign empty              = !out_valid;

endmodule

>>> rtl/jts_item_queue.sv
`timescale 1ns / 1ps
// front part: small queue of accepted transactions, head classified as load or solve
module jts_item_queue import jts_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t in_item,
  output logic  full,
  output logic  head_vld,
  output item_t head_item,
  output logic  head_is_solve,
  input  logic  take
);

  item_t      q_r [QUEUE_DEPTH];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full          = (cnt_r == 3'(QUEUE_DEPTH));
  assign head_vld      = (cnt_r != 3'd0);
  assign head_item     = q_r[rd_ptr_r];
  assign head_is_solve = (q_r[rd_ptr_r].op == OP_SOLVE);
  assign do_push       = push && !full;
  assign do_pop        = take && head_vld;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 2'd1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 2'd1 : rd_ptr_r;
    cnt_nxt    = cnt_r + 3'(do_push) - 3'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

>>> rtl/jts_engine.sv
`timescale 1ns / 1ps
// back part: rhs store, ping-pong solution memory, sweep sequencer and residual pipe
module jts_engine import jts_pkg::*; #(
  parameter int MAX_SIZE    = MAX_SIZE_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  logic         q_vld,
  input  item_t        q_item,
  input  logic         q_is_solve,
  output logic         q_take,
  output logic         out_valid,
  input  logic         out_take,
  output logic [5:0]   out_position,
  output logic [31:0]  out_solution_value,
  output logic [13:0]  out_sweep_count,
  output logic [62:0]  out_residual_squared,
  output logic         out_limit_hit,
  output logic         out_last
);

  localparam int VW = VALUE_WIDTH;
  localparam int SW = VW + 2;
  localparam int EW = VW + 3;
  localparam int IW = $clog2(MAX_SIZE);
  localparam int NW = IW + 1;
  localparam int DEPTH = 2 ** IW;
  localparam logic signed [63:0] V_HI = (64'sd1 <<< (VW - 1)) - 64'sd1;
  localparam logic signed [63:0] V_LO = -V_HI - 64'sd1;
  localparam logic signed [63:0] O_HI = 64'sd2147483647;
  localparam logic signed [63:0] O_LO = -64'sd2147483648;
  localparam logic [6:0] MAX_N = 7'(MAX_SIZE);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PRE    = 3'd1;
  localparam logic [2:0] ST_PRE2   = 3'd2;
  localparam logic [2:0] ST_CALC   = 3'd3;
  localparam logic [2:0] ST_TAIL   = 3'd4;
  localparam logic [2:0] ST_DRAIN  = 3'd5;
  localparam logic [2:0] ST_DECIDE = 3'd6;
  localparam logic [2:0] ST_EMIT   = 3'd7;

  logic [2:0]          state_r;
  logic [NW-1:0]       n_r;
  logic [IW-1:0]       i_r;
  logic [IW-1:0]       p_r;
  logic                bank_r;
  logic                first_sweep_r;
  logic [13:0]         sweeps_r;
  logic [62:0]         first_r;
  logic [62:0]         acc_r;
  logic [62:0]         res_r;
  logic                limit_r;
  logic [1:0]          drain_r;
  logic                rd_pend_r;

  logic signed [VW-1:0] o_m1_r, o0_r, f0_r, f_m1_r, n_m1_r, n_m2_r;

  logic signed [VW-1:0] rhs_mem [DEPTH];
  logic signed [VW-1:0] sol_mem [2 * DEPTH];
  logic signed [VW-1:0] rhs_rd_r, sol_rd_r;

  // residual pipe
  logic                 t_v_r, u_v_r, s_v_r;
  logic signed [VW-1:0] t_a_r, t_b_r, t_c_r, t_f_r;
  logic [31:0]          u_r;
  logic                 u_over_r;
  logic [62:0]          sq_r;

  logic [6:0]           ps;
  logic [NW-1:0]        n_c;
  logic [IW-1:0]        rd_idx;
  logic                 next_out;
  logic signed [VW-1:0] onext;
  logic signed [SW-1:0] s_sum, s_half;
  logic signed [VW-1:0] newv;
  logic signed [63:0]   ld64, ld_sat;
  logic                 ld_we;
  logic signed [EW-1:0] e_val, e_abs;
  logic [63:0]          a64;
  logic [63:0]          prod;
  logic [63:0]          acc_sum;
  logic [62:0]          first_eff;
  logic signed [63:0]   sol64;
  logic [31:0]          sol32;
  logic                 issue;
  logic                 is_last;

  // problem size clamped into the supported range
  always_comb begin
    ps = cfg.problem_size;
    if (ps < 7'd3) begin
      n_c = NW'(3);
    end else if (ps > MAX_N) begin
      n_c = NW'(MAX_SIZE);
    end else begin
      n_c = ps[NW-1:0];
    end
  end

  assign q_take = (state_r == ST_IDLE) && q_vld;

  // load path: sign-extend and saturate into the stored width
  always_comb begin
    ld64 = 64'($signed(q_item.rhs_value));
    if (ld64 > V_HI) begin
      ld_sat = V_HI;
    end else if (ld64 < V_LO) begin
      ld_sat = V_LO;
    end else begin
      ld_sat = ld64;
    end
    ld_we = q_take && !q_is_solve && (7'(q_item.index) < MAX_N);
  end

  always_comb begin
    case (state_r)
      ST_PRE:  rd_idx = '0;
      ST_PRE2: rd_idx = IW'(1);
      ST_CALC: rd_idx = i_r + IW'(2);
      ST_EMIT: rd_idx = p_r;
      default: rd_idx = '0;
    endcase
  end

  // jacobi update for element i
  always_comb begin
    next_out = ({1'b0, i_r} + NW'(1)) >= n_r;
    onext    = (first_sweep_r || next_out) ? '0 : sol_rd_r;
    s_sum    = SW'(f0_r) + SW'(o_m1_r) + SW'(onext);
    s_half   = s_sum >>> 1;
    if (s_half > SW'(V_HI)) begin
      newv = VW'(V_HI);
    end else if (s_half < SW'(V_LO)) begin
      newv = VW'(V_LO);
    end else begin
      newv = VW'(s_half);
    end
  end

  // residual term, square and saturating sum
  always_comb begin
    e_val   = (EW'(t_b_r) <<< 1) - EW'(t_a_r) - EW'(t_c_r) - EW'(t_f_r);
    e_abs   = (e_val < 0) ? -e_val : e_val;
    a64     = 64'($unsigned(e_abs));
    prod    = 64'(u_r) * 64'(u_r);
    acc_sum = {1'b0, acc_r} + {1'b0, sq_r};
  end

  assign first_eff = (sweeps_r == 14'd1) ? acc_r : first_r;

  // emission path
  always_comb begin
    issue   = (state_r == ST_EMIT) && !rd_pend_r && (!out_valid || out_take);
    is_last = ({1'b0, p_r} == n_r - NW'(1));
    sol64   = 64'(sol_rd_r);
    if (sol64 > O_HI) begin
      sol32 = 32'(O_HI);
    end else if (sol64 < O_LO) begin
      sol32 = 32'(O_LO);
    end else begin
      sol32 = 32'(sol64);
    end
  end

  always_ff @(posedge clk) begin
    if (ld_we) begin
      rhs_mem[q_item.index[IW-1:0]] <= VW'(ld_sat);
    end
    rhs_rd_r <= rhs_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CALC) begin
      sol_mem[{~bank_r, i_r}] <= newv;
    end
    sol_rd_r <= sol_mem[{bank_r, rd_idx}];
  end

  always_ff @(posedge clk) begin
    t_a_r    <= n_m2_r;
    t_b_r    <= n_m1_r;
    t_c_r    <= (state_r == ST_TAIL) ? '0 : newv;
    t_f_r    <= f_m1_r;
    u_r      <= a64[31:0];
    u_over_r <= a64 > ABS_SQ_MAX;
    sq_r     <= u_over_r ? RES_MAX : prod[62:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= 1'b0;
      u_v_r <= 1'b0;
      s_v_r <= 1'b0;
    end else begin
      t_v_r <= ((state_r == ST_CALC) && (i_r != '0)) || (state_r == ST_TAIL);
      u_v_r <= t_v_r;
      s_v_r <= u_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      n_r           <= n_c;
      i_r           <= '0;
      p_r           <= '0;
      bank_r        <= 1'b0;
      first_sweep_r <= 1'b1;
      sweeps_r      <= '0;
      first_r       <= '0;
      acc_r         <= '0;
      res_r         <= '0;
      limit_r       <= 1'b0;
      drain_r       <= '0;
      rd_pend_r     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (s_v_r) begin
        acc_r <= (acc_sum > {1'b0, RES_MAX}) ? RES_MAX : acc_sum[62:0];
      end
      if (out_take && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_take && q_is_solve) begin
            n_r           <= n_c;
            bank_r        <= 1'b0;
            first_sweep_r <= 1'b1;
            sweeps_r      <= '0;
            first_r       <= '0;
            limit_r       <= 1'b0;
            state_r       <= ST_PRE;
          end
        end
        ST_PRE: begin
          i_r     <= '0;
          state_r <= ST_PRE2;
        end
        ST_PRE2: begin
          o_m1_r  <= '0;
          o0_r    <= first_sweep_r ? '0 : sol_rd_r;
          f0_r    <= rhs_rd_r;
          n_m1_r  <= '0;
          acc_r   <= '0;
          state_r <= ST_CALC;
        end
        ST_CALC: begin
          o_m1_r <= o0_r;
          o0_r   <= onext;
          f_m1_r <= f0_r;
          f0_r   <= rhs_rd_r;
          n_m2_r <= n_m1_r;
          n_m1_r <= newv;
          if ({1'b0, i_r} == n_r - NW'(1)) begin
            state_r <= ST_TAIL;
          end else begin
            i_r <= i_r + IW'(1);
          end
        end
        ST_TAIL: begin
          sweeps_r <= sweeps_r + 14'd1;
          drain_r  <= 2'd2;
          state_r  <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (drain_r == 2'd0) begin
            state_r <= ST_DECIDE;
          end else begin
            drain_r <= drain_r - 2'd1;
          end
        end
        ST_DECIDE: begin
          bank_r        <= ~bank_r;
          first_sweep_r <= 1'b0;
          first_r       <= first_eff;
          res_r         <= acc_r;
          if (sweeps_r > {1'b0, cfg.iteration_limit}) begin
            limit_r   <= 1'b1;
            p_r       <= '0;
            rd_pend_r <= 1'b0;
            state_r   <= ST_EMIT;
          end else if (acc_r > (first_eff >> cfg.tolerance_shift)) begin
            state_r <= ST_PRE;
          end else begin
            p_r       <= '0;
            rd_pend_r <= 1'b0;
            state_r   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          rd_pend_r <= issue;
          if (rd_pend_r) begin
            out_valid <= 1'b1;
            if (is_last) begin
              state_r <= ST_IDLE;
            end else begin
              p_r <= p_r + IW'(1);
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend_r) begin
      out_position         <= 6'(p_r);
      out_solution_value   <= sol32;
      out_sweep_count      <= sweeps_r;
      out_residual_squared <= res_r;
      out_limit_hit        <= limit_r;
      out_last             <= is_last;
    end
  end

  a_load_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |=> out_valid)
    else $error("pending solution read did not reach the output register");

  a_sweeps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) |-> (sweeps_r <= {1'b0, cfg.iteration_limit}))
    else $error("sweep started beyond the iteration limit");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CALC) |-> ({1'b0, i_r} < n_r))
    else $error("sweep index beyond problem size");

endmodule
